>>> hdl/ssbs_pkg.sv
// Package: shared types, constants and hash helpers for the bitmap sketch
package ssbs_pkg;

    localparam int unsigned TableEntriesDefault = 1024;
    localparam logic [9:0]  IndexMaskReset      = 10'd1023;
    localparam logic [6:0]  ThresholdReset      = 7'd32;
    localparam logic [6:0]  CountMax            = 7'd64;
    localparam logic [31:0] HashSeed            = 32'd1;

    localparam logic [0:0] CfgIndexMask = 1'b0;
    localparam logic [0:0] CfgThreshold = 1'b1;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  entry_index;
        logic [6:0]  distinct_count;
        logic        over_threshold;
        logic [31:0] reported_src;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic hash_step;
        logic read_req;
        logic write_back;
        logic clear_wr;
        logic load_out;
    } dp_cmd_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

    // Fold four destination bytes into a bit position 0..63
    function automatic logic [5:0] dest_fold(input logic [31:0] dst);
        logic [7:0] v;
        v = dst[7:0] ^ dst[15:8] ^ dst[23:16] ^ dst[31:24];
        v = v ^ (v >> 2);
        dest_fold = v[5:0];
    endfunction

endpackage

>>> hdl/ssbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module ssbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

>>> hdl/ssbs_datapath.sv
// Datapath: staged MurmurHash3, table read-modify-write and result register
module ssbs_datapath #(
    parameter int unsigned TABLE_ENTRIES = ssbs_pkg::TableEntriesDefault
) (
    input  logic                 aclk,
    input  ssbs_pkg::dp_cmd_t   cmd,
    input  logic [2:0]          hash_phase,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] clear_addr,
    input  ssbs_pkg::in_item_t  s_item,
    input  logic [9:0]          index_mask,
    input  logic [6:0]          report_threshold,
    output ssbs_pkg::out_item_t m_item
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    // Tables of 1024 entries or more hold every ten-bit index as it is
    localparam bit          NoReduce = (TABLE_ENTRIES >= 1024);
    localparam logic [9:0]  EntriesW = NoReduce ? 10'd0 : 10'(TABLE_ENTRIES);
    localparam logic [9:0]  RecipW   = NoReduce ? 10'd0 : 10'(1024 / TABLE_ENTRIES);

    logic [31:0] src_reg;
    logic [5:0]  pos_reg;
    logic [31:0] h_reg, h_next;
    logic [AW-1:0] idx_reg;
    logic [63:0] bm_rd, bm_new, bm_wd;
    logic [6:0]  cnt_rd, cnt_new, cnt_wd;
    logic [AW-1:0] wa;
    logic [9:0]  masked;
    logic [19:0] quot_prod;
    logic [9:0]  quot;
    logic [19:0] back_prod;
    logic [9:0]  rem;
    logic [9:0]  reduced;
    logic [63:0] bit_sel;

    // One multiply or mix step per phase
    always_comb begin
        h_next = h_reg;
        case (hash_phase)
            3'd0: h_next = src_reg * 32'hcc9e2d51;
            3'd1: h_next = ssbs_pkg::rotl32(h_reg, 15) * 32'h1b873593;
            3'd2: h_next = ssbs_pkg::rotl32(ssbs_pkg::HashSeed ^ h_reg, 13);
            3'd3: h_next = ((h_reg * 32'd5 + 32'he6546b64) ^ 32'd4);
            3'd4: h_next = (h_reg ^ (h_reg >> 16)) * 32'h85ebca6b;
            3'd5: h_next = (h_reg ^ (h_reg >> 13)) * 32'hc2b2ae35;
            3'd6: h_next = h_reg ^ (h_reg >> 16);
            default: h_next = h_reg;
        endcase
    end

    // Reduce masked hash to the table size: reciprocal estimate of the
    // quotient (at most one low), then one corrective subtract
    always_comb begin
        masked    = h_reg[9:0] & index_mask;
        quot_prod = '0;
        quot      = '0;
        back_prod = '0;
        rem       = masked;
        reduced   = masked;
        if (!NoReduce) begin
            quot_prod = masked * RecipW;
            quot      = quot_prod[19:10];
            back_prod = quot * EntriesW;
            rem       = masked - back_prod[9:0];
            if (rem >= EntriesW) begin
                rem = rem - EntriesW;
            end
            reduced   = rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            src_reg <= s_item.src_ip;
            pos_reg <= ssbs_pkg::dest_fold(s_item.dst_ip);
        end
        if (cmd.hash_step) begin
            h_reg <= h_next;
        end
        if (cmd.read_req) begin
            idx_reg <= AW'(reduced);
        end
    end

    // Update bitmap and count, or zero them at the clear address during the clearing pass
    always_comb begin
        bit_sel = 64'd1 << pos_reg;
        bm_new  = bm_rd | bit_sel;
        cnt_new = cnt_rd;
        if (((bm_rd & bit_sel) == 64'd0) && (cnt_rd < ssbs_pkg::CountMax)) begin
            cnt_new = cnt_rd + 7'd1;
        end
        wa    = cmd.clear_wr ? clear_addr : idx_reg;
        bm_wd = cmd.clear_wr ? 64'd0 : bm_new;
        cnt_wd = cmd.clear_wr ? 7'd0 : cnt_new;
    end

    ssbs_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_bitmap (
        .aclk(aclk), .wr_en(cmd.write_back | cmd.clear_wr), .wr_addr(wa),
        .wr_data(bm_wd), .rd_addr(idx_reg), .rd_data(bm_rd)
    );

    ssbs_ram #(.WIDTH(7), .DEPTH(TABLE_ENTRIES)) u_count (
        .aclk(aclk), .wr_en(cmd.write_back | cmd.clear_wr), .wr_addr(wa),
        .wr_data(cnt_wd), .rd_addr(idx_reg), .rd_data(cnt_rd)
    );

    // Hold result for the output transfer
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_item.entry_index    <= 10'(idx_reg);
            m_item.distinct_count <= cnt_new;
            m_item.over_threshold <= cnt_new > report_threshold;
            m_item.reported_src   <= src_reg;
        end
    end

endmodule

>>> hdl/ssbs_ctrl.sv
// Controller: clearing pass, hash sequencing, read-modify-write and handshakes
module ssbs_ctrl #(
    parameter int unsigned TABLE_ENTRIES = ssbs_pkg::TableEntriesDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ssbs_pkg::dp_cmd_t cmd,
    output logic [2:0]        hash_phase,
    output logic [$clog2(TABLE_ENTRIES)-1:0] clear_addr
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_INDEX, ST_READ, ST_UPDATE, ST_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] phase_reg;
    logic [AW-1:0] clr_reg;
    logic mv_reg;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = mv_reg;
    assign hash_phase = phase_reg;
    assign clear_addr = clr_reg;

    always_comb begin
        cmd = '0;
        cmd.clear_wr   = (state_reg == ST_CLEAR);
        cmd.load_in    = (state_reg == ST_IDLE) && s_valid;
        cmd.hash_step  = (state_reg == ST_HASH);
        cmd.read_req   = (state_reg == ST_INDEX);
        cmd.write_back = (state_reg == ST_UPDATE);
        cmd.load_out   = (state_reg == ST_UPDATE);
    end

    // Advance the sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            phase_reg <= '0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TABLE_ENTRIES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        phase_reg <= '0;
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    phase_reg <= phase_reg + 3'd1;
                    if (phase_reg == 3'd6) begin
                        state_reg <= ST_INDEX;
                    end
                end
                ST_INDEX:  state_reg <= ST_READ;
                ST_READ:   state_reg <= ST_UPDATE;
                ST_UPDATE: begin
                    mv_reg    <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        mv_reg    <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_valid_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid == (state_reg == ST_OUT)) else $error("m_valid out of step");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("accept while result pending");
    a_hash_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HASH && phase_reg == 3'd6) |=> state_reg == ST_INDEX)
        else $error("hash sequence broken");
    a_wb_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_back |=> !cmd.write_back) else $error("double write-back");

endmodule

>>> hdl/superspreader_bitmap_sketch_top.sv
// Top level: superspreader bitmap sketch
//  channel   | ports                         | direction
//  s_        | s_valid s_ready s_data        | packet in
//  m_        | m_valid m_ready m_data        | result out
//  cfg_      | cfg_valid cfg_ready cfg_index cfg_data | register write
// From transfer in to result valid an item passes 7 hash steps, the index step, the
// RAM read and the update; one item is in flight at a time, so the next input is
// not taken until the result has been transferred out.
// After reset a clearing pass zeroes every table entry before s_ready rises.
// A stalled result holds the block; configuration writes are always taken.
module superspreader_bitmap_sketch_top #(
    parameter int unsigned TABLE_ENTRIES = ssbs_pkg::TableEntriesDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssbs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssbs_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    ssbs_pkg::dp_cmd_t cmd;
    logic [2:0] phase;
    logic [$clog2(TABLE_ENTRIES)-1:0] caddr;
    logic [9:0] mask_reg;
    logic [6:0] thr_reg;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= ssbs_pkg::IndexMaskReset;
            thr_reg  <= ssbs_pkg::ThresholdReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                ssbs_pkg::CfgIndexMask: mask_reg <= cfg_data[9:0];
                ssbs_pkg::CfgThreshold: thr_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ssbs_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .hash_phase(phase),
        .clear_addr(caddr)
    );

    ssbs_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk(aclk), .cmd(cmd), .hash_phase(phase), .clear_addr(caddr),
        .s_item(s_data), .index_mask(mask_reg), .report_threshold(thr_reg),
        .m_item(m_data)
    );

endmodule
